// ----- sv/ulid_pkg.sv -----
// Shared types, constants and the base32 alphabet for the ULID generator.
package ulid_pkg;

   localparam int unsigned TS_W       = 48;
   localparam int unsigned RAND_W     = 80;
   localparam int unsigned ID_W       = TS_W + RAND_W;
   localparam int unsigned RC4_BYTES  = 10;
   localparam int unsigned CHAR_COUNT = 26;
   localparam int unsigned CHAR_W     = 7;

   // Item codes
   localparam logic ACT_MIX = 1'b0;
   localparam logic ACT_GEN = 1'b1;

   // Register indexes
   localparam logic CSR_RELAXED  = 1'b0;
   localparam logic CSR_PARANOID = 1'b1;

   typedef logic [7:0] perm_byte_type;

   // One request to the permutation memory per cycle: a read, a write, both or neither
   typedef struct packed {
      logic          rd_en;
      perm_byte_type rd_addr;
      logic          wr_en;
      perm_byte_type wr_addr;
      perm_byte_type wr_data;
   } mem_req_type;

   // Crockford base32: 0-9, A-Z without I, L, O, U
   function automatic logic [CHAR_W-1:0] crockford_char(input logic [4:0] v);
      logic [CHAR_W-1:0] c;
      case (v)
         5'd0:  c = 7'h30;
         5'd1:  c = 7'h31;
         5'd2:  c = 7'h32;
         5'd3:  c = 7'h33;
         5'd4:  c = 7'h34;
         5'd5:  c = 7'h35;
         5'd6:  c = 7'h36;
         5'd7:  c = 7'h37;
         5'd8:  c = 7'h38;
         5'd9:  c = 7'h39;
         5'd10: c = 7'h41;
         5'd11: c = 7'h42;
         5'd12: c = 7'h43;
         5'd13: c = 7'h44;
         5'd14: c = 7'h45;
         5'd15: c = 7'h46;
         5'd16: c = 7'h47;
         5'd17: c = 7'h48;
         5'd18: c = 7'h4a;
         5'd19: c = 7'h4b;
         5'd20: c = 7'h4d;
         5'd21: c = 7'h4e;
         5'd22: c = 7'h50;
         5'd23: c = 7'h51;
         5'd24: c = 7'h52;
         5'd25: c = 7'h53;
         5'd26: c = 7'h54;
         5'd27: c = 7'h56;
         5'd28: c = 7'h57;
         5'd29: c = 7'h58;
         5'd30: c = 7'h59;
         default: c = 7'h5a;
      endcase
      return c;
   endfunction

endpackage

// ----- sv/ulid_if.sv -----
// Channel interfaces: request words, character words and register writes.
interface ulid_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic [7:0]  key_byte;
   logic [47:0] timestamp_ms;

   modport source (output valid, output action, output key_byte, output timestamp_ms,
                   input ready);
   modport sink   (input valid, input action, input key_byte, input timestamp_ms,
                   output ready);
endinterface

interface ulid_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] char_code;
   logic       last_char;

   modport source (output valid, output char_code, output last_char, input ready);
   modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface ulid_csr_if;
   logic valid;
   logic ready;
   logic addr;
   logic wdata;

   modport source (output valid, output addr, output wdata, input ready);
   modport sink   (input valid, input addr, input wdata, output ready);
endinterface

// ----- sv/ulid_perm_mem.sv -----
// RC4 permutation store: memory with separate read and write ports, registered read and per-entry valid bits.
module ulid_perm_mem
   import ulid_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  mem_req_type   mem_req,
   output perm_byte_type rd_data
);

   perm_byte_type mem [256];
   logic [255:0]  valid_ff;
   perm_byte_type rd_mem_ff;
   perm_byte_type rd_addr_ff;
   logic          rd_valid_ff;

   // Storage and registered read
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_mem_ff  <= mem[mem_req.rd_addr];
         rd_addr_ff <= mem_req.rd_addr;
      end
   end

   // Written-since-reset flags; unwritten entries read as their own index
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (mem_req.wr_en) begin
            valid_ff[mem_req.wr_addr] <= 1'b1;
         end
         if (mem_req.rd_en) begin
            rd_valid_ff <= valid_ff[mem_req.rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_mem_ff : rd_addr_ff;

endmodule

// ----- sv/ulid_emit.sv -----
// Base32 serialiser: shifts the identifier out five bits a word into an output register.
module ulid_emit
   import ulid_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  logic [ID_W-1:0]   id,
   output logic              busy,
   ulid_rsp_if.source        rsp_chan
);

   localparam int unsigned SHIFT_W = 5 * CHAR_COUNT;

   logic [SHIFT_W-1:0] shift_ff, shift_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               valid_ff, valid_in;
   logic [CHAR_W-1:0]  char_ff, char_in;
   logic               last_ff, last_in;

   always_comb begin
      shift_in = shift_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      valid_in = valid_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      // word taken downstream
      if (valid_ff && rsp_chan.ready) begin
         valid_in = 1'b0;
      end
      // next character into the output register when it is free
      if (busy_ff && (!valid_ff || rsp_chan.ready)) begin
         valid_in = 1'b1;
         char_in  = crockford_char(shift_ff[SHIFT_W-1 -: 5]);
         last_in  = (cnt_ff == 5'(CHAR_COUNT - 1));
         shift_in = {shift_ff[SHIFT_W-6:0], 5'b0};
         cnt_in   = cnt_ff + 5'd1;
         if (cnt_ff == 5'(CHAR_COUNT - 1)) begin
            busy_in = 1'b0;
         end
      end else if (load && !busy_ff) begin
         shift_in = {(SHIFT_W - ID_W)'(0), id};
         cnt_in   = '0;
         busy_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
      shift_ff <= shift_in;
      cnt_ff   <= cnt_in;
      char_ff  <= char_in;
      last_ff  <= last_in;
   end

   assign busy               = busy_ff;
   assign rsp_chan.valid     = valid_ff;
   assign rsp_chan.char_code = char_ff;
   assign rsp_chan.last_char = last_ff;

endmodule

// ----- sv/ulid_generator_rc4.sv -----
// ULID generator top level: sequencer around the RC4 permutation memory and the serialiser.
// A key word (action 0) runs one RC4 key-schedule step. A generate word (action 1)
// with a repeated timestamp, outside relaxed mode, increments the 80-bit random part;
// otherwise it draws ten RC4 bytes, each through the steps RC_I, RC_A, RC_B, RC_WJ, RC_T
// and RC_OUT. Each step makes at most one access to the 256-byte permutation memory.
// The 26 characters then leave at one word a cycle while the sink is ready;
// a following word is taken meanwhile, but its characters wait until the previous
// identifier has been sent. The permutation reads as identity after reset with no
// clearing pass. Register writes are taken on any cycle; only bit 0 is kept.
module ulid_generator_rc4
   import ulid_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   ulid_req_if.sink   req_chan,
   ulid_rsp_if.source rsp_chan,
   ulid_csr_if.sink   csr_chan
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MIX_A,
      ST_MIX_B,
      ST_MIX_WJ,
      ST_RC_I,
      ST_RC_A,
      ST_RC_B,
      ST_RC_WJ,
      ST_RC_T,
      ST_RC_OUT,
      ST_EMIT
   } state_type;

   state_type       state_ff, state_in;
   perm_byte_type   mix_index_ff, mix_index_in;
   perm_byte_type   mix_accum_ff, mix_accum_in;
   perm_byte_type   stream_i_ff, stream_i_in;
   perm_byte_type   stream_j_ff, stream_j_in;
   logic [TS_W-1:0] last_time_ff, last_time_in;
   logic [ID_W-1:0] id_ff, id_in;
   logic [3:0]      byte_cnt_ff, byte_cnt_in;
   perm_byte_type   key_ff, key_in;
   perm_byte_type   a_ff, a_in;
   perm_byte_type   b_ff, b_in;
   perm_byte_type   j_ff, j_in;
   logic            relaxed_ff, paranoid_ff;

   mem_req_type     mem_req;
   perm_byte_type   rd_data;
   logic            emit_load;
   logic            emit_busy;
   logic            req_fire;

   ulid_perm_mem u_perm (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   ulid_emit u_emit (
      .clock    (clock),
      .reset    (reset),
      .load     (emit_load),
      .id       (id_ff),
      .busy     (emit_busy),
      .rsp_chan (rsp_chan)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   // Sequencer: each step issues at most one memory access
   always_comb begin
      state_in     = state_ff;
      mix_index_in = mix_index_ff;
      mix_accum_in = mix_accum_ff;
      stream_i_in  = stream_i_ff;
      stream_j_in  = stream_j_ff;
      last_time_in = last_time_ff;
      id_in        = id_ff;
      byte_cnt_in  = byte_cnt_ff;
      key_in       = key_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      j_in         = j_ff;
      mem_req      = '0;
      emit_load    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_chan.action == ACT_MIX) begin
                  key_in          = req_chan.key_byte;
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = mix_index_ff;
                  state_in        = ST_MIX_A;
               end else if (!relaxed_ff && (req_chan.timestamp_ms == last_time_ff)) begin
                  id_in[RAND_W-1:0] = id_ff[RAND_W-1:0] + RAND_W'(1);
                  state_in          = ST_EMIT;
               end else begin
                  last_time_in           = req_chan.timestamp_ms;
                  id_in[ID_W-1:RAND_W]   = req_chan.timestamp_ms;
                  byte_cnt_in            = '0;
                  state_in               = ST_RC_I;
               end
            end
         end
         // key schedule: j = accum + P[idx] + key, swap P[idx] and P[j]
         ST_MIX_A: begin
            a_in            = rd_data;
            j_in            = mix_accum_ff + rd_data + key_ff;
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = mix_accum_ff + rd_data + key_ff;
            state_in        = ST_MIX_B;
         end
         ST_MIX_B: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = mix_index_ff;
            mem_req.wr_data = rd_data;
            state_in        = ST_MIX_WJ;
         end
         ST_MIX_WJ: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = j_ff;
            mem_req.wr_data = a_ff;
            mix_index_in    = mix_index_ff + 8'd1;
            // pass ends when the index wraps
            mix_accum_in    = (mix_index_ff == 8'hff) ? 8'd0 : j_ff;
            state_in        = ST_IDLE;
         end
         // output generation: one byte per six steps
         ST_RC_I: begin
            stream_i_in     = stream_i_ff + 8'd1;
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = stream_i_ff + 8'd1;
            state_in        = ST_RC_A;
         end
         ST_RC_A: begin
            a_in            = rd_data;
            stream_j_in     = stream_j_ff + rd_data;
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = stream_j_ff + rd_data;
            state_in        = ST_RC_B;
         end
         ST_RC_B: begin
            b_in            = rd_data;
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = stream_i_ff;
            mem_req.wr_data = rd_data;
            state_in        = ST_RC_WJ;
         end
         ST_RC_WJ: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = stream_j_ff;
            mem_req.wr_data = a_ff;
            state_in        = ST_RC_T;
         end
         ST_RC_T: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = a_ff + b_ff;
            state_in        = ST_RC_OUT;
         end
         ST_RC_OUT: begin
            // first byte ends up most significant
            id_in[RAND_W-1:0] = {id_ff[RAND_W-9:0], rd_data};
            if (byte_cnt_ff == 4'(RC4_BYTES - 1)) begin
               if (paranoid_ff) begin
                  id_in[RAND_W-1] = 1'b0;
               end
               state_in = ST_EMIT;
            end else begin
               byte_cnt_in = byte_cnt_ff + 4'd1;
               state_in    = ST_RC_I;
            end
         end
         ST_EMIT: begin
            if (!emit_busy) begin
               emit_load = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mix_index_ff <= '0;
         mix_accum_ff <= '0;
         stream_i_ff  <= '0;
         stream_j_ff  <= '0;
         last_time_ff <= '0;
         id_ff        <= '0;
         byte_cnt_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         mix_index_ff <= mix_index_in;
         mix_accum_ff <= mix_accum_in;
         stream_i_ff  <= stream_i_in;
         stream_j_ff  <= stream_j_in;
         last_time_ff <= last_time_in;
         id_ff        <= id_in;
         byte_cnt_ff  <= byte_cnt_in;
      end
      key_ff <= key_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      j_ff   <= j_in;
   end

   // Mode registers
   always_ff @(posedge clock) begin
      if (reset) begin
         relaxed_ff  <= 1'b0;
         paranoid_ff <= 1'b0;
      end else if (csr_chan.valid && csr_chan.ready) begin
         if (csr_chan.addr == CSR_RELAXED) begin
            relaxed_ff <= csr_chan.wdata;
         end
         if (csr_chan.addr == CSR_PARANOID) begin
            paranoid_ff <= csr_chan.wdata;
         end
      end
   end

`ifndef ASSERT_OFF
   // the sequencer never reads and writes the permutation in the same cycle
   a_mem_one_access: assert property (@(posedge clock) disable iff (reset)
      !(mem_req.rd_en && mem_req.wr_en))
      else $error("permutation read and write in one cycle");

   // the identifier is only handed over when the serialiser is free
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      emit_load |-> !emit_busy)
      else $error("identifier loaded while serialiser busy");

   // a key word never starts a new identifier
   a_mix_quiet: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_chan.action == ACT_MIX) |=> !emit_load ##1 !emit_load)
      else $error("key word started an identifier");

   // a waiting character word holds until it is taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.ready) |=>
         (rsp_chan.valid && $stable(rsp_chan.char_code) && $stable(rsp_chan.last_char)))
      else $error("character word changed while waiting");
`endif

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the ULID generator: predicts every character word and scores the DUT.
module tb;
   import ulid_pkg::*;

   typedef struct {
      logic        action;
      logic [7:0]  key_byte;
      logic [47:0] stamp;
   } req_word_type;

   typedef struct {
      logic [CHAR_W-1:0] code;
      logic              last;
   } char_word_type;

   // Crockford digits, first character in the top byte
   localparam logic [8*32-1:0] B32_DIGITS    = "0123456789ABCDEFGHJKMNPQRSTVWXYZ";
   localparam int unsigned     QUIET_LIMIT   = 5000;
   localparam int unsigned     SETTLE_CYCLES = 16;
   localparam int unsigned     PHASE_WORDS   = 16;
   localparam int unsigned     SEED_WORDS    = 240;
   // {relaxed, paranoid} per random phase after the first
   localparam logic [1:0]      MODE_PLAN [4] = '{2'b10, 2'b01, 2'b11, 2'b00};

   logic clock = 1'b0;
   logic reset;

   ulid_req_if req_chan();
   ulid_rsp_if rsp_chan();
   ulid_csr_if csr_chan();

   ulid_generator_rc4 dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // Predictor state
   logic [7:0]      sbox [256];
   logic [7:0]      ksa_i, ksa_j, prga_i, prga_j;
   logic [47:0]     held_stamp;
   logic [ID_W-1:0] id_now;
   logic            relaxed_on, paranoid_on;

   char_word_type chars_due [$];
   req_word_type  words_pending [$];
   req_word_type  word_held;
   logic [47:0] stim_stamp;
   int          mismatches = 0;
   int          req_gap, req_calm, rsp_stall, rsp_calm;
   int          quiet_cycles;

   always #5 clock = ~clock;

   function automatic void swap_sbox(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] t;
      t       = sbox[a];
      sbox[a] = sbox[b];
      sbox[b] = t;
   endfunction

   // One key-schedule step; the pass restarts its accumulator on index wrap
   function automatic void schedule_key(input logic [7:0] key);
      logic [7:0] j;
      j = ksa_j + sbox[ksa_i] + key;
      swap_sbox(ksa_i, j);
      ksa_j = j;
      ksa_i = ksa_i + 8'd1;
      if (ksa_i == 8'd0) ksa_j = 8'd0;
   endfunction

   function automatic logic [7:0] keystream_byte();
      logic [7:0] sum;
      prga_i = prga_i + 8'd1;
      prga_j = prga_j + sbox[prga_i];
      swap_sbox(prga_i, prga_j);
      sum = sbox[prga_i] + sbox[prga_j];
      return sbox[sum];
   endfunction

   // Build the next identifier and queue its 26 characters
   function automatic void issue_ulid(input logic [47:0] stamp);
      logic [ID_W+1:0] padded;
      logic [4:0]      digit;
      char_word_type   cw;
      if (!relaxed_on && stamp == held_stamp) begin
         // repeated millisecond: bump the random part, wrapping silently
         id_now[RAND_W-1:0] = id_now[RAND_W-1:0] + 80'd1;
      end else begin
         held_stamp = stamp;
         id_now[ID_W-1 -: TS_W] = stamp;
         for (int k = 0; k < RC4_BYTES; k++) begin
            id_now[RAND_W-1-8*k -: 8] = keystream_byte();
         end
         if (paranoid_on) id_now[RAND_W-1] = 1'b0;
      end
      padded = {2'b00, id_now};
      for (int k = 0; k < CHAR_COUNT; k++) begin
         digit   = padded[ID_W+1-5*k -: 5];
         cw.code = B32_DIGITS[8*(31-digit) +: 7];
         cw.last = (k == CHAR_COUNT-1);
         chars_due.push_back(cw);
      end
   endfunction

   // Idle length: mostly short, a few long, with occasional stretches of none
   function automatic int idle_span(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         calm = $urandom_range(20, 60);
         return 0;
      end
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic void queue_word(input logic act, input logic [7:0] key,
                                      input logic [47:0] stamp);
      req_word_type w;
      w.action   = act;
      w.key_byte = key;
      w.stamp    = stamp;
      if (act == ACT_GEN) stim_stamp = stamp;
      words_pending.push_back(w);
   endfunction

   // Mostly plausible timestamp sequences: repeats, small steps, some jumps
   function automatic void queue_random_word();
      logic [47:0] stamp;
      logic [7:0]  key;
      int          r;
      r     = $urandom_range(0, 99);
      key   = 8'($urandom);
      stamp = {16'($urandom), $urandom};
      if (r < 35) begin
         queue_word(ACT_MIX, key, stamp);
      end else begin
         if (r < 60) stamp = stim_stamp;
         else if (r < 80) stamp = stim_stamp + 48'($urandom_range(1, 3));
         else if (r >= 93) stamp = (r < 97) ? '0 : '1;
         queue_word(ACT_GEN, key, stamp);
      end
   endfunction

   task automatic write_reg(input logic idx, input logic val);
      @(posedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.addr  <= idx;
      csr_chan.wdata <= val;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      if (idx == CSR_RELAXED) relaxed_on = val;
      else paranoid_on = val;
   endtask

   // Wait for every word sent and every character back, then let a key step finish
   task automatic settle_idle();
      do @(negedge clock);
      while (words_pending.size() != 0 || req_chan.valid || chars_due.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Request driver
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_gap = 0;
         req_calm = 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            if (word_held.action == ACT_MIX) schedule_key(word_held.key_byte);
            else issue_ulid(word_held.stamp);
            req_gap = idle_span(req_calm);
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_chan.valid <= 1'b0;
            end else if (words_pending.size() > 0) begin
               word_held = words_pending.pop_front();
               req_chan.valid        <= 1'b1;
               req_chan.action       <= word_held.action;
               req_chan.key_byte     <= word_held.key_byte;
               req_chan.timestamp_ms <= word_held.stamp;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Character monitor and scoreboard
   always @(posedge clock) begin
      char_word_type want;
      logic          took;
      took = rsp_chan.valid && rsp_chan.ready;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rsp_stall = 0;
         rsp_calm = 0;
      end else begin
         if (took) begin
            if (chars_due.size() == 0) begin
               mismatches++;
               $display("%0t: character with none due: expected none, actual code %h last %b",
                        $time, rsp_chan.char_code, rsp_chan.last_char);
            end else begin
               want = chars_due.pop_front();
               if (rsp_chan.char_code !== want.code) begin
                  mismatches++;
                  $display("%0t: char_code: expected %h, actual %h",
                           $time, want.code, rsp_chan.char_code);
               end
               if (rsp_chan.last_char !== want.last) begin
                  mismatches++;
                  $display("%0t: last_char: expected %b, actual %b",
                           $time, want.last, rsp_chan.last_char);
               end
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
            if (took || $urandom_range(0, 7) == 0) rsp_stall = idle_span(rsp_calm);
         end
      end
   end

   // Watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || (csr_chan.valid && csr_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Stimulus
   initial begin
      reset                 = 1'b1;
      req_chan.valid        = 1'b0;
      req_chan.action       = ACT_MIX;
      req_chan.key_byte     = 8'd0;
      req_chan.timestamp_ms = 48'd0;
      rsp_chan.ready        = 1'b0;
      csr_chan.valid        = 1'b0;
      csr_chan.addr         = CSR_RELAXED;
      csr_chan.wdata        = 1'b0;
      quiet_cycles          = 0;

      for (int k = 0; k < 256; k++) sbox[k] = 8'(k);
      ksa_i       = '0;
      ksa_j       = '0;
      prga_i      = '0;
      prga_j      = '0;
      held_stamp  = '0;
      id_now      = '0;
      relaxed_on  = 1'b0;
      paranoid_on = 1'b0;
      stim_stamp  = '0;

      // directed: zero stamp straight after reset counts as a repeat
      queue_word(ACT_GEN, 8'h00, 48'h0);
      queue_word(ACT_GEN, 8'hff, 48'h0);
      queue_word(ACT_MIX, 8'h00, 48'hffff_ffff_ffff);
      queue_word(ACT_MIX, 8'hff, 48'h0);
      queue_word(ACT_MIX, 8'h80, 48'h5555_5555_5555);
      queue_word(ACT_MIX, 8'h01, 48'haaaa_aaaa_aaaa);
      queue_word(ACT_GEN, 8'h5a, 48'hffff_ffff_ffff);
      queue_word(ACT_GEN, 8'ha5, 48'hffff_ffff_ffff);
      queue_word(ACT_GEN, 8'h00, 48'h0000_0000_0001);
      queue_word(ACT_GEN, 8'h00, 48'h8000_0000_0000);
      queue_word(ACT_GEN, 8'h00, 48'h7fff_ffff_ffff);
      queue_word(ACT_GEN, 8'h00, 48'h7fff_ffff_ffff);
      queue_word(ACT_GEN, 8'h00, 48'h0);
      queue_word(ACT_GEN, 8'h00, 48'h0);

      // key schedule run; the random words after it can carry the index past its wrap
      for (int k = 0; k < SEED_WORDS; k++) begin
         queue_word(ACT_MIX, 8'($urandom), {16'($urandom), $urandom});
      end
      for (int k = 0; k < PHASE_WORDS; k++) queue_random_word();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // random phases under each mode setting
      foreach (MODE_PLAN[p]) begin
         settle_idle();
         write_reg(CSR_RELAXED, MODE_PLAN[p][1]);
         write_reg(CSR_PARANOID, MODE_PLAN[p][0]);
         @(negedge clock);
         if (MODE_PLAN[p][0]) queue_word(ACT_GEN, 8'h00, 48'hffff_ffff_ffff);
         for (int k = 0; k < PHASE_WORDS; k++) queue_random_word();
      end

      settle_idle();
      if (mismatches == 0 && chars_due.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
sv/ulid_pkg.sv
sv/ulid_if.sv
sv/ulid_perm_mem.sv
sv/ulid_emit.sv
sv/ulid_generator_rc4.sv
tb/tb.sv
